// File: rtl/bclp_pkg.sv
// ----------------------------------------------------------------------------
// Braille canvas line plotter - shared definitions
// Canvas geometry, word layouts, controller states and the braille dot table
// used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package bclp_pkg;

	// Canvas geometry and storage layout.
	localparam int CELL_COLS  = 128;
	localparam int CELL_ROWS  = 64;
	localparam int COLOR_BITS = 24;
	localparam int CELL_COUNT = CELL_COLS * CELL_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	// Field widths of the command and result words.
	localparam int FUNC_W    = 2;
	localparam int COORD_W   = 8;
	localparam int IN_COLOR_W = 24;
	localparam int CCOL_W    = 7;
	localparam int CROW_W    = 6;
	localparam int GLYPH_W   = 14;
	localparam int DOTS_W    = 8;
	localparam int ACC_W     = COORD_W + 1;

	localparam logic [GLYPH_W-1:0] GLYPH_BASE = 14'h2800;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_POINT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]     func;
		logic [COORD_W-1:0]    start_x;
		logic [COORD_W-1:0]    start_y;
		logic [COORD_W-1:0]    end_x;
		logic [COORD_W-1:0]    end_y;
		logic [IN_COLOR_W-1:0] color;
		logic [CCOL_W-1:0]     cell_col;
		logic [CROW_W-1:0]     cell_row;
	} cmd_t;

	typedef struct packed {
		logic [GLYPH_W-1:0]    glyph_code;
		logic [IN_COLOR_W-1:0] cell_color;
		logic                  occupied;
		logic                  done_res;
	} rsp_t;

	// One canvas cell as held in the store.
	typedef struct packed {
		logic [DOTS_W-1:0]     dots;
		logic [COLOR_BITS-1:0] color;
	} cell_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DOT_RD,
		S_DOT_WR,
		S_CELL_RD,
		S_CELL_OUT
	} state_t;

	// Which result word the datapath builds.
	typedef enum logic [1:0] {
		RSP_DONE,
		RSP_NOOP,
		RSP_CELL
	} rsp_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      clear_en;
		logic      load_walk;
		logic      load_cell;
		logic      read_en;
		logic      use_cell;
		logic      write_en;
		logic      step;
		logic      rsp_load;
		rsp_kind_t rsp_kind;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic dot_last;
		logic cell_in_range;
	} sts_t;

	// Braille dot bit for a dot at (row mod 4, column mod 2) inside its cell.
	function automatic logic [DOTS_W-1:0] dot_mask(input logic [1:0] sub_row,
			input logic sub_col);
		logic [DOTS_W-1:0] m;
		case (sub_row)
			2'd0:    m = sub_col ? 8'h08 : 8'h01;
			2'd1:    m = sub_col ? 8'h10 : 8'h02;
			2'd2:    m = sub_col ? 8'h20 : 8'h04;
			default: m = sub_col ? 8'h80 : 8'h40;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/bclp_ctrl.sv
// ----------------------------------------------------------------------------
// Braille canvas line plotter - controller
// Sequences the clearing sweep, the read-modify-write of each plotted dot,
// cell reads and the loading of the result word.
// ----------------------------------------------------------------------------
module bclp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bclp_pkg::FUNC_W-1:0]   func,
	input  bclp_pkg::sts_t                sts,
	output logic                          busy,
	output bclp_pkg::ctl_t                ctl
);
	import bclp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					case (func)
						FUNC_POINT, FUNC_LINE: state_nxt = S_DOT_RD;
						FUNC_READ: begin
							if (sts.cell_in_range) state_nxt = S_CELL_RD;
						end
						default: state_nxt = S_IDLE;
					endcase
				end
			end
			S_DOT_RD:   state_nxt = S_DOT_WR;
			S_DOT_WR:   state_nxt = sts.dot_last ? S_IDLE : S_DOT_RD;
			S_CELL_RD:  state_nxt = S_CELL_OUT;
			S_CELL_OUT: state_nxt = S_IDLE;
			default:    state_nxt = S_CLEAR;
		endcase
	end

	// Datapath commands.
	always_comb begin
		ctl = '0;
		ctl.rsp_kind = RSP_DONE;
		case (state_q)
			S_CLEAR: ctl.clear_en = 1'b1;
			S_IDLE: begin
				if (start) begin
					case (func)
						FUNC_POINT, FUNC_LINE: ctl.load_walk = 1'b1;
						FUNC_READ: begin
							if (sts.cell_in_range) begin
								ctl.load_cell = 1'b1;
							end else begin
								ctl.rsp_load = 1'b1;
								ctl.rsp_kind = RSP_DONE;
							end
						end
						default: begin
							ctl.rsp_load = 1'b1;
							ctl.rsp_kind = RSP_NOOP;
						end
					endcase
				end
			end
			S_DOT_RD: ctl.read_en = 1'b1;
			S_DOT_WR: begin
				ctl.write_en = 1'b1;
				if (sts.dot_last) begin
					ctl.rsp_load = 1'b1;
					ctl.rsp_kind = RSP_DONE;
				end else begin
					ctl.step = 1'b1;
				end
			end
			S_CELL_RD: begin
				ctl.read_en  = 1'b1;
				ctl.use_cell = 1'b1;
			end
			S_CELL_OUT: begin
				ctl.rsp_load = 1'b1;
				ctl.rsp_kind = RSP_CELL;
			end
			default: ctl.clear_en = 1'b0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// The clearing sweep only ever hands over to idle.
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |=> state_q == S_CLEAR || state_q == S_IDLE)
		else $error("clearing sweep left to a state other than idle");

	// Every dot read is followed by its write-back.
	a_rmw_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DOT_RD |=> state_q == S_DOT_WR)
		else $error("dot read not followed by its write-back");

	// A walk that has not reached its last dot keeps going.
	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DOT_WR && !sts.dot_last |=> state_q == S_DOT_RD)
		else $error("line walk stopped before its last dot");

	// An accepted in-range cell read goes to the store.
	a_cell_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && start && func == FUNC_READ && sts.cell_in_range
		|=> state_q == S_CELL_RD)
		else $error("in-range cell read did not access the store");

endmodule

// File: rtl/bclp_datapath.sv
// ----------------------------------------------------------------------------
// Braille canvas line plotter - datapath
// Holds the canvas store, the clearing counter, the line walker with its
// exact rational row accumulator, and the result register.
// ----------------------------------------------------------------------------
module bclp_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  bclp_pkg::cmd_t   cmd,
	input  bclp_pkg::ctl_t   ctl,
	output bclp_pkg::sts_t   sts,
	output logic             rsp_valid,
	output bclp_pkg::rsp_t   rsp
);
	import bclp_pkg::*;

	// Canvas store.
	cell_t mem [CELL_COUNT];

	logic [ADDR_W-1:0]     clr_q;
	logic [COORD_W-1:0]    x_q, y_q, x1_q, y1_q, dx_q, dy_q;
	logic                  down_q;
	logic [ACC_W-1:0]      acc_q;
	logic [COLOR_BITS-1:0] color_q;
	logic [ADDR_W-1:0]     cell_addr_q;
	cell_t                 rdata_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic [COORD_W-1:0]    ex, ey, x0_n, y0_n, x1_n, y1_n, dx_n, dy_n;
	logic                  down_n;
	logic [ACC_W-1:0]      acc_n;
	logic                  vertical;
	logic                  acc_ge;
	logic                  acc_ge2;
	logic                  dot_in_range;
	logic [ADDR_W-1:0]     dot_addr;
	logic [ADDR_W-1:0]     cmd_addr;
	logic [ADDR_W-1:0]     raddr;
	logic [ADDR_W-1:0]     waddr;
	logic                  mem_we;
	cell_t                 wdata;

	// Endpoint ordering for a new walk; a point is a line of one dot.
	always_comb begin
		ex = (cmd.func == FUNC_POINT) ? cmd.start_x : cmd.end_x;
		ey = (cmd.func == FUNC_POINT) ? cmd.start_y : cmd.end_y;
		if (cmd.start_x > ex) begin
			x0_n = ex;
			y0_n = ey;
			x1_n = cmd.start_x;
			y1_n = cmd.start_y;
		end else begin
			x0_n = cmd.start_x;
			y0_n = cmd.start_y;
			x1_n = ex;
			y1_n = ey;
		end
		dx_n   = x1_n - x0_n;
		down_n = (y1_n >= y0_n);
		dy_n   = down_n ? (y1_n - y0_n) : (y0_n - y1_n);
		// Going up the rows rounds the offset up, hence the bias of dx - 1.
		acc_n  = down_n ? ACC_W'(dy_n) : (ACC_W'(dy_n) + ACC_W'(dx_n) - ACC_W'(1));
	end

	assign vertical = (dx_q == '0);
	assign acc_ge   = (acc_q >= ACC_W'(dx_q));
	assign acc_ge2  = (acc_q >= {dx_q, 1'b0});

	// Line walker: one dot per step, rows first within a column. The row
	// that the next column starts on is reached together with the column
	// step, so it is never plotted in the current column.
	always_ff @(posedge clk) begin
		if (ctl.load_walk) begin
			x_q     <= x0_n;
			y_q     <= y0_n;
			x1_q    <= x1_n;
			y1_q    <= y1_n;
			dx_q    <= dx_n;
			dy_q    <= dy_n;
			down_q  <= down_n;
			acc_q   <= acc_n;
			color_q <= cmd.color[COLOR_BITS-1:0];
		end else if (ctl.step) begin
			if (vertical) begin
				y_q <= down_q ? y_q + COORD_W'(1) : y_q - COORD_W'(1);
			end else if (acc_ge2) begin
				acc_q <= acc_q - ACC_W'(dx_q);
				y_q   <= down_q ? y_q + COORD_W'(1) : y_q - COORD_W'(1);
			end else if (acc_ge) begin
				acc_q <= acc_q - ACC_W'(dx_q) + ACC_W'(dy_q);
				y_q   <= down_q ? y_q + COORD_W'(1) : y_q - COORD_W'(1);
				x_q   <= x_q + COORD_W'(1);
			end else begin
				acc_q <= acc_q + ACC_W'(dy_q);
				x_q   <= x_q + COORD_W'(1);
			end
		end
	end

	// Cell address of the current dot and of a cell read.
	assign dot_in_range = (int'(x_q[COORD_W-1:1]) < CELL_COLS)
		&& (int'(y_q[COORD_W-1:2]) < CELL_ROWS);
	assign dot_addr = ADDR_W'(int'(y_q[COORD_W-1:2]) * CELL_COLS
		+ int'(x_q[COORD_W-1:1]));
	assign cmd_addr = ADDR_W'(int'(cmd.cell_row) * CELL_COLS + int'(cmd.cell_col));

	always_ff @(posedge clk) begin
		if (ctl.load_cell) cell_addr_q <= cmd_addr;
	end

	// Clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear_en) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// Store port: one write and one registered read per cycle.
	assign raddr = ctl.use_cell ? cell_addr_q : dot_addr;
	assign waddr = ctl.clear_en ? clr_q : dot_addr;
	assign mem_we = ctl.clear_en || (ctl.write_en && dot_in_range);
	always_comb begin
		if (ctl.clear_en) begin
			wdata = '0;
		end else begin
			wdata.dots  = rdata_q.dots | dot_mask(y_q[1:0], x_q[0]);
			wdata.color = color_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (ctl.read_en) rdata_q <= mem[raddr];
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (ctl.rsp_load) begin
			rsp_q.done_res <= (ctl.rsp_kind != RSP_NOOP);
			if (ctl.rsp_kind == RSP_CELL) begin
				rsp_q.glyph_code <= GLYPH_BASE + GLYPH_W'(rdata_q.dots);
				rsp_q.cell_color <= IN_COLOR_W'(rdata_q.color);
				rsp_q.occupied   <= |rdata_q.dots;
			end else begin
				rsp_q.glyph_code <= GLYPH_BASE;
				rsp_q.cell_color <= '0;
				rsp_q.occupied   <= 1'b0;
			end
		end
	end

	// Result strobe lasts exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= ctl.rsp_load;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status back to the controller.
	assign sts.clear_last    = (clr_q == ADDR_W'(CELL_COUNT - 1));
	assign sts.dot_last      = vertical ? (y_q == y1_q) : (x_q == x1_q);
	assign sts.cell_in_range = (int'(cmd.cell_col) < CELL_COLS)
		&& (int'(cmd.cell_row) < CELL_ROWS);

endmodule

// File: rtl/braille_canvas_line_plotter_core.sv
// ----------------------------------------------------------------------------
// Braille canvas line plotter
// Braille dot canvas with point plots, left-to-right line plots and cell
// reads, built as a controller and a datapath around one canvas store.
// ----------------------------------------------------------------------------
//  Channel  | Ports                  | Handshake
//  ---------+------------------------+-------------------------------------
//  command  | start, busy, cmd       | word taken when start and not busy
//  result   | rsp_valid, rsp         | one-cycle strobe, cannot be held off
//
//  A point plot is one store read and one write-back, a line one of each per
//  plotted dot, a cell read a store read and the result load; an invalid
//  function code or an out-of-range read answers in the accept cycle. The
//  result strobe follows in the cycle after the last of these.
//  After reset the store is swept clear, one cell per cycle, with busy high.
//  The receiver cannot stall; every result is strobed once.
// ----------------------------------------------------------------------------
module braille_canvas_line_plotter_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bclp_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             rsp_valid,
	output bclp_pkg::rsp_t   rsp
);
	import bclp_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Controller.
	bclp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (cmd.func),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Datapath with the canvas store.
	bclp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
